// ----- sv/lzw_pkg.sv -----
// Shared types and constants for the LZW encoder with LSB-first code packing.
// Used by the controller, the datapath and the top level; no dependencies.
package lzw_pkg;

    localparam int HASH_SLOTS   = 8192;
    localparam int HASH_AW      = $clog2(HASH_SLOTS);
    localparam int CODE_W       = 12;
    localparam int NCODE_W      = CODE_W + 1;
    localparam int WIDTH_W      = 4;
    localparam int CNT_W        = 24;
    localparam int ENTRY_W      = 1 + CODE_W + 8 + CODE_W;

    localparam logic [CODE_W-1:0]  CODE_CLEAR  = CODE_W'(256);
    localparam logic [CODE_W-1:0]  CODE_EOI    = CODE_W'(257);
    localparam logic [NCODE_W-1:0] CODE_FIRST  = NCODE_W'(258);
    localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(9);
    localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(CODE_W);
    localparam logic [CNT_W-1:0]   LIMIT_RESET = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        SEL_CLEAR,
        SEL_EOI,
        SEL_PFX
    } code_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_SWEEP_S,
        ST_START,
        ST_PK_CLR,
        ST_PREF,
        ST_CHK,
        ST_PK_PFX,
        ST_INS,
        ST_PK_FULL,
        ST_SWEEP_F,
        ST_LAST_CHK,
        ST_PK_LAST,
        ST_PK_EOI,
        ST_FLUSH,
        ST_MARK
    } state_t;

    typedef struct packed {
        logic      accept;
        logic      go_idle;
        logic      sweep;
        logic      start;
        logic      load;
        code_sel_t load_sel;
        logic      final_code;
        logic      pack;
        logic      rd;
        logic      probe;
        logic      take_hit;
        logic      insert;
        logic      set_pfx_byte;
        logic      pfx_to_byte;
        logic      flush;
        logic      mark;
    } cmd_t;

    typedef struct packed {
        logic ovf;
        logic started;
        logic pv;
        logic last;
        logic hit;
        logic empty;
        logic pack_done;
        logic dict_full;
        logic out_free;
        logic sweep_last;
        logic fill_zero;
    } sts_t;

endpackage

// ----- sv/lzw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/lzw_ctrl.sv -----
// Controller state machine of the LZW encoder: sequences hash probing, code
// packing, dictionary sweeps and stream end. Depends on lzw_pkg.
module lzw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 in_ready,
    input  lzw_pkg::sts_t        sts,
    output lzw_pkg::cmd_t        cmd
);

    lzw_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lzw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lzw_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = lzw_pkg::ST_ENTRY;
            end
            lzw_pkg::ST_ENTRY: begin
                if (sts.ovf) state_next = lzw_pkg::ST_IDLE;
                else if (!sts.started) state_next = lzw_pkg::ST_SWEEP_S;
                else state_next = lzw_pkg::ST_PREF;
            end
            lzw_pkg::ST_SWEEP_S: begin
                if (sts.sweep_last) state_next = lzw_pkg::ST_START;
            end
            lzw_pkg::ST_START: state_next = lzw_pkg::ST_PK_CLR;
            lzw_pkg::ST_PK_CLR: begin
                if (sts.pack_done) begin
                    state_next = sts.ovf ? lzw_pkg::ST_MARK : lzw_pkg::ST_PREF;
                end
            end
            lzw_pkg::ST_PREF: begin
                state_next = sts.pv ? lzw_pkg::ST_CHK : lzw_pkg::ST_LAST_CHK;
            end
            lzw_pkg::ST_CHK: begin
                if (sts.hit) state_next = lzw_pkg::ST_LAST_CHK;
                else if (sts.empty) state_next = lzw_pkg::ST_PK_PFX;
            end
            lzw_pkg::ST_PK_PFX: begin
                if (sts.pack_done) begin
                    if (sts.ovf) state_next = lzw_pkg::ST_MARK;
                    else if (sts.dict_full) state_next = lzw_pkg::ST_PK_FULL;
                    else state_next = lzw_pkg::ST_INS;
                end
            end
            lzw_pkg::ST_INS: state_next = lzw_pkg::ST_LAST_CHK;
            lzw_pkg::ST_PK_FULL: begin
                if (sts.pack_done) begin
                    state_next = sts.ovf ? lzw_pkg::ST_MARK : lzw_pkg::ST_SWEEP_F;
                end
            end
            lzw_pkg::ST_SWEEP_F: begin
                if (sts.sweep_last) state_next = lzw_pkg::ST_LAST_CHK;
            end
            lzw_pkg::ST_LAST_CHK: begin
                state_next = sts.last ? lzw_pkg::ST_PK_LAST : lzw_pkg::ST_IDLE;
            end
            lzw_pkg::ST_PK_LAST: begin
                if (sts.pack_done) begin
                    state_next = sts.ovf ? lzw_pkg::ST_MARK : lzw_pkg::ST_PK_EOI;
                end
            end
            lzw_pkg::ST_PK_EOI: begin
                if (sts.pack_done) begin
                    state_next = sts.ovf ? lzw_pkg::ST_MARK : lzw_pkg::ST_FLUSH;
                end
            end
            lzw_pkg::ST_FLUSH: begin
                if (sts.fill_zero) state_next = lzw_pkg::ST_IDLE;
            end
            lzw_pkg::ST_MARK: begin
                if (sts.out_free) state_next = lzw_pkg::ST_IDLE;
            end
            default: state_next = lzw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.load_sel = lzw_pkg::SEL_PFX;
        in_ready     = 1'b0;
        case (state_reg)
            lzw_pkg::ST_IDLE: begin
                in_ready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            lzw_pkg::ST_ENTRY: begin
                // An aborted stream swallows bytes until its final one.
                cmd.go_idle = sts.ovf && sts.last;
            end
            lzw_pkg::ST_SWEEP_S: cmd.sweep = 1'b1;
            lzw_pkg::ST_START: begin
                cmd.start    = 1'b1;
                cmd.load     = 1'b1;
                cmd.load_sel = lzw_pkg::SEL_CLEAR;
            end
            lzw_pkg::ST_PK_CLR, lzw_pkg::ST_PK_LAST, lzw_pkg::ST_PK_EOI: begin
                cmd.pack = !sts.pack_done;
                if (state_reg == lzw_pkg::ST_PK_LAST && sts.pack_done && !sts.ovf) begin
                    cmd.load       = 1'b1;
                    cmd.load_sel   = lzw_pkg::SEL_EOI;
                    cmd.final_code = 1'b1;
                end
            end
            lzw_pkg::ST_PREF: begin
                cmd.rd           = sts.pv;
                cmd.set_pfx_byte = !sts.pv;
            end
            lzw_pkg::ST_CHK: begin
                cmd.take_hit = sts.hit;
                cmd.load     = !sts.hit && sts.empty;
                cmd.probe    = !sts.hit && !sts.empty;
            end
            lzw_pkg::ST_PK_PFX: begin
                cmd.pack = !sts.pack_done;
                if (sts.pack_done && !sts.ovf && sts.dict_full) begin
                    cmd.load     = 1'b1;
                    cmd.load_sel = lzw_pkg::SEL_CLEAR;
                end
            end
            lzw_pkg::ST_INS: cmd.insert = 1'b1;
            lzw_pkg::ST_PK_FULL: cmd.pack = !sts.pack_done;
            lzw_pkg::ST_SWEEP_F: begin
                cmd.sweep       = 1'b1;
                cmd.pfx_to_byte = sts.sweep_last;
            end
            lzw_pkg::ST_LAST_CHK: cmd.load = sts.last;
            lzw_pkg::ST_FLUSH: begin
                cmd.flush   = !sts.fill_zero;
                cmd.go_idle = sts.fill_zero;
            end
            lzw_pkg::ST_MARK: begin
                cmd.mark    = sts.out_free;
                cmd.go_idle = sts.out_free && sts.last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

// ----- sv/lzw_dp.sv -----
// Datapath of the LZW encoder: input capture, dictionary hash memory, code
// bit packer, byte counter and output register. Depends on lzw_pkg, lzw_ram.
module lzw_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lzw_pkg::cmd_t              cmd,
    output lzw_pkg::sts_t              sts,
    input  logic [7:0]                 s_tdata,   // in_byte
    input  logic                       s_tlast,
    input  logic                       cfg_valid,
    input  logic [lzw_pkg::CNT_W-1:0]  cfg_data,
    output logic [31:0]                m_tdata,   // out_byte, total_bytes
    output logic                       m_tuser,   // overflow
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready
);

    localparam int AW = lzw_pkg::HASH_AW;
    localparam int CW = lzw_pkg::CODE_W;
    localparam int NW = lzw_pkg::NCODE_W;
    localparam int WW = lzw_pkg::WIDTH_W;
    localparam int KW = lzw_pkg::CNT_W;

    logic [7:0]    byte_reg, byte_next;
    logic          last_reg, last_next;
    logic [CW-1:0] prefix_reg, prefix_next;
    logic          pv_reg, pv_next;
    logic [NW-1:0] ncode_reg, ncode_next;
    logic [WW-1:0] width_reg, width_next;
    logic [7:0]    partial_reg, partial_next;
    logic [2:0]    fill_reg, fill_next;
    logic [KW-1:0] bytes_reg, bytes_next;
    logic          ovf_reg, ovf_next;
    logic          started_reg, started_next;
    logic [CW-1:0] code_reg, code_next;
    logic [WW-1:0] rem_reg, rem_next;
    logic          final_reg, final_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [KW-1:0] olimit_reg, olimit_next;
    logic          mv_reg, mv_next;
    logic [7:0]    ob_reg, ob_next;
    logic          ol_reg, ol_next;
    logic          ou_reg, ou_next;
    logic [KW-1:0] ot_reg, ot_next;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [lzw_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic [CW+7:0] key;
    logic [AW-1:0] hash;
    logic          out_free;
    logic [WW-1:0] avail, n;
    logic [WW-1:0] new_fill;
    logic [15:0]   shifted;
    logic [7:0]    merged;
    logic [NW-1:0] ncode_inc;
    logic [NW-1:0] wlimit;

    lzw_ram #(
        .WIDTH(lzw_pkg::ENTRY_W),
        .DEPTH(lzw_pkg::HASH_SLOTS)
    ) u_hash (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // The key times 257 modulo the slot count: the key plus the key shifted by 8.
    assign key  = {prefix_reg, byte_reg};
    assign hash = key[AW-1:0] + {key[AW-9:0], 8'd0};

    assign out_free  = !mv_reg || m_tready;
    assign avail     = WW'(8) - {1'b0, fill_reg};
    assign n         = (rem_reg < avail) ? rem_reg : avail;
    assign new_fill  = {1'b0, fill_reg} + n;
    assign shifted   = {{(16-CW){1'b0}}, code_reg} << fill_reg;
    assign merged    = partial_reg | shifted[7:0];
    assign ncode_inc = ncode_reg + NW'(1);
    assign wlimit    = NW'(1) << width_reg;

    always_comb begin
        sts.ovf        = ovf_reg;
        sts.started    = started_reg;
        sts.pv         = pv_reg;
        sts.last       = last_reg;
        sts.empty      = !ram_rdata[lzw_pkg::ENTRY_W-1];
        sts.hit        = ram_rdata[lzw_pkg::ENTRY_W-1]
                         && (ram_rdata[CW+8+CW-1:CW+8] == prefix_reg)
                         && (ram_rdata[CW+7:CW] == byte_reg);
        sts.pack_done  = (rem_reg == '0) || ovf_reg;
        sts.dict_full  = ncode_reg[NW-1];
        sts.out_free   = out_free;
        sts.sweep_last = (clr_reg == {AW{1'b1}});
        sts.fill_zero  = (fill_reg == 3'd0);
    end

    always_comb begin
        byte_next    = byte_reg;
        last_next    = last_reg;
        prefix_next  = prefix_reg;
        pv_next      = pv_reg;
        ncode_next   = ncode_reg;
        width_next   = width_reg;
        partial_next = partial_reg;
        fill_next    = fill_reg;
        bytes_next   = bytes_reg;
        ovf_next     = ovf_reg;
        started_next = started_reg;
        code_next    = code_reg;
        rem_next     = rem_reg;
        final_next   = final_reg;
        slot_next    = slot_reg;
        clr_next     = clr_reg;
        olimit_next  = cfg_valid ? cfg_data : olimit_reg;
        mv_next      = mv_reg && !m_tready;
        ob_next      = ob_reg;
        ol_next      = ol_reg;
        ou_next      = ou_reg;
        ot_next      = ot_reg;
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = '0;
        ram_raddr    = hash;

        if (cmd.accept) begin
            byte_next = s_tdata;
            last_next = s_tlast;
        end
        if (cmd.sweep) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            clr_next  = clr_reg + AW'(1);
            if (sts.sweep_last) begin
                ncode_next = lzw_pkg::CODE_FIRST;
                width_next = lzw_pkg::START_WIDTH;
            end
        end
        if (cmd.start) begin
            bytes_next   = '0;
            partial_next = '0;
            fill_next    = '0;
            pv_next      = 1'b0;
            started_next = 1'b1;
        end
        if (cmd.load) begin
            case (cmd.load_sel)
                lzw_pkg::SEL_CLEAR: code_next = lzw_pkg::CODE_CLEAR;
                lzw_pkg::SEL_EOI:   code_next = lzw_pkg::CODE_EOI;
                default:            code_next = prefix_reg;
            endcase
            rem_next   = width_reg;
            final_next = cmd.final_code;
        end
        if (cmd.rd) begin
            slot_next = hash;
        end
        if (cmd.probe) begin
            ram_raddr = slot_reg + AW'(1);
            slot_next = slot_reg + AW'(1);
        end
        if (cmd.take_hit) begin
            prefix_next = ram_rdata[CW-1:0];
        end
        if (cmd.set_pfx_byte) begin
            prefix_next = CW'(byte_reg);
            pv_next     = 1'b1;
        end
        if (cmd.pfx_to_byte) begin
            prefix_next = CW'(byte_reg);
        end
        if (cmd.insert) begin
            ram_we      = 1'b1;
            ram_wdata   = {1'b1, prefix_reg, byte_reg, ncode_reg[CW-1:0]};
            ncode_next  = ncode_inc;
            prefix_next = CW'(byte_reg);
            // Late change: widen once the next free code reaches the limit.
            if (ncode_inc == wlimit && width_reg < lzw_pkg::MAX_WIDTH) begin
                width_next = width_reg + WW'(1);
            end
        end
        if (cmd.pack) begin
            if (fill_reg == 3'd0 && bytes_reg >= olimit_reg) begin
                ovf_next = 1'b1;
                rem_next = '0;
            end else if (new_fill != WW'(8)) begin
                partial_next = merged;
                fill_next    = new_fill[2:0];
                code_next    = code_reg >> n;
                rem_next     = rem_reg - n;
            end else if (out_free) begin
                mv_next      = 1'b1;
                ob_next      = merged;
                ol_next      = last_reg && final_reg && (rem_reg == n);
                ou_next      = 1'b0;
                ot_next      = bytes_reg + KW'(1);
                bytes_next   = bytes_reg + KW'(1);
                partial_next = '0;
                fill_next    = '0;
                code_next    = code_reg >> n;
                rem_next     = rem_reg - n;
            end
        end
        if (cmd.flush && out_free) begin
            mv_next      = 1'b1;
            ob_next      = partial_reg;
            ol_next      = 1'b1;
            ou_next      = 1'b0;
            ot_next      = bytes_reg + KW'(1);
            bytes_next   = bytes_reg + KW'(1);
            partial_next = '0;
            fill_next    = '0;
        end
        if (cmd.mark) begin
            mv_next = 1'b1;
            ob_next = '0;
            ol_next = 1'b1;
            ou_next = 1'b1;
            ot_next = bytes_reg;
        end
        if (cmd.go_idle) begin
            started_next = 1'b0;
            pv_next      = 1'b0;
            prefix_next  = '0;
            ovf_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg  <= '0;
            pv_reg      <= 1'b0;
            ncode_reg   <= lzw_pkg::CODE_FIRST;
            width_reg   <= lzw_pkg::START_WIDTH;
            partial_reg <= '0;
            fill_reg    <= '0;
            bytes_reg   <= '0;
            ovf_reg     <= 1'b0;
            started_reg <= 1'b0;
            rem_reg     <= '0;
            clr_reg     <= '0;
            olimit_reg  <= lzw_pkg::LIMIT_RESET;
            mv_reg      <= 1'b0;
        end else begin
            prefix_reg  <= prefix_next;
            pv_reg      <= pv_next;
            ncode_reg   <= ncode_next;
            width_reg   <= width_next;
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
            bytes_reg   <= bytes_next;
            ovf_reg     <= ovf_next;
            started_reg <= started_next;
            rem_reg     <= rem_next;
            clr_reg     <= clr_next;
            olimit_reg  <= olimit_next;
            mv_reg      <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        code_reg  <= code_next;
        final_reg <= final_next;
        slot_reg  <= slot_next;
        ob_reg    <= ob_next;
        ol_reg    <= ol_next;
        ou_reg    <= ou_next;
        ot_reg    <= ot_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {ot_reg, ob_reg};
    assign m_tlast  = ol_reg;
    assign m_tuser  = ou_reg;

endmodule

// ----- sv/lzw_encoder_lsb_packed_top.sv -----
// Per input byte: a byte that opens a prefix passes ENTRY, PREF and LAST_CHK before the next
// ready; a dictionary hit also passes CHK. A miss adds a probe per hash collision, the packing
// of the prefix code (9 to 12 bits), an insert, and any wait while the receiver stalls.
// Throughput: one output byte per cycle at most. A stream's first byte and every
// dictionary-full CLEAR run a sweep of all 8192 hash RAM slots while no item is accepted.
// Reset (aresetn low, synchronous) idles the block, sets output_limit to all ones.
module lzw_encoder_lsb_packed_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte [7:0], total_bytes [31:8]
    output logic        m_tlast,
    output logic        m_tuser,   // overflow
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data   // output_limit
);

    lzw_pkg::cmd_t cmd;
    lzw_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    lzw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .in_ready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lzw_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule
